// ----- hdl/nlsc_pkg.sv -----
// shared types, constants and byte table for the nal length to start code converter
`timescale 1ns / 1ps

package nlsc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned FS_W     = 3;
    localparam int unsigned SEEN_W   = 3;
    localparam int unsigned IDX_W    = 4;

    localparam logic [FS_W-1:0] FS_RESET = 3'd4;

    // positions in the combined per-item byte list
    localparam logic [IDX_W-1:0] IDX_AUD_FIRST = 4'd0;
    localparam logic [IDX_W-1:0] IDX_AUD_LAST  = 4'd5;
    localparam logic [IDX_W-1:0] IDX_SC_FIRST  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_SC_LAST   = 4'd8;
    localparam logic [IDX_W-1:0] IDX_PAY       = 4'd9;

    localparam logic [BYTE_W-1:0] AUD_NAL_TYPE = 8'h09;
    localparam logic [BYTE_W-1:0] AUD_PAYLOAD  = 8'hE0;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    // what one accepted item produces
    typedef struct packed {
        logic              aud;
        logic              sc;
        logic              pay;
        logic [BYTE_W-1:0] data;
    } desc_t;

    // byte at a position of the list: delimiter, start code, payload
    function automatic logic [BYTE_W-1:0] list_byte(input logic [IDX_W-1:0] idx,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] b;
        b = '0;
        case (idx)
            4'd3:    b = 8'h01;
            4'd4:    b = AUD_NAL_TYPE;
            4'd5:    b = AUD_PAYLOAD;
            4'd8:    b = 8'h01;
            4'd9:    b = data;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/nlsc_parse.sv -----
// sample parser: length field tracking, drop decision and item descriptor register
`timescale 1ns / 1ps

module nlsc_parse
    import nlsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [FS_W-1:0]   cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              first_of_sample,
    input  logic [LEN_W-1:0]  sample_length,
    output logic              desc_valid,
    input  logic              desc_ready,
    output desc_t             desc
);

    logic [FS_W-1:0]   fs_reg;
    phase_t            phase_reg,   phase_next;
    logic [LEN_W-1:0]  acc_reg,     acc_next;
    logic [SEEN_W-1:0] seen_reg,    seen_next;
    logic [LEN_W-1:0]  pay_left_reg, pay_left_next;
    logic [LEN_W-1:0]  smp_left_reg, smp_left_next;
    logic              desc_valid_reg, desc_valid_next;
    desc_t             desc_reg,    desc_next;

    logic              accept;
    logic              fs_ok;
    logic              emit_sc;
    logic              emit_pay;
    logic [LEN_W-1:0]  sl;
    logic [LEN_W-1:0]  acc_shift;
    logic [SEEN_W-1:0] seen_inc;

    assign in_ready   = !desc_valid_reg || desc_ready;
    assign accept     = in_valid && in_ready;
    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

    assign fs_ok = (fs_reg == 3'd1) || (fs_reg == 3'd2) || (fs_reg == 3'd4);

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        pay_left_next = pay_left_reg;
        sl            = smp_left_reg;
        emit_sc       = 1'b0;
        emit_pay      = 1'b0;

        if (first_of_sample)
        begin
            sl            = sample_length;
            phase_next    = PH_LENGTH;
            acc_next      = '0;
            seen_next     = '0;
            pay_left_next = '0;
        end

        acc_shift     = {acc_next[LEN_W-BYTE_W-1:0], in_byte};
        seen_inc      = seen_next + 3'd1;
        smp_left_next = sl;

        if (sl != '0)
        begin
            smp_left_next = sl - 32'd1;
            case (phase_next)
                PH_LENGTH:
                begin
                    if (seen_next == '0 && (!fs_ok || sl < {{(LEN_W-FS_W){1'b0}}, fs_reg}))
                    begin
                        phase_next = PH_DROP;
                    end
                    else
                    begin
                        acc_next  = acc_shift;
                        seen_next = seen_inc;
                        if (seen_inc == fs_reg)
                        begin
                            if (acc_shift > smp_left_next)
                            begin
                                phase_next = PH_DROP;
                            end
                            else
                            begin
                                emit_sc       = 1'b1;
                                pay_left_next = acc_shift;
                                phase_next    = (acc_shift == '0) ? PH_LENGTH : PH_PAYLOAD;
                                acc_next      = '0;
                                seen_next     = '0;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    emit_pay      = 1'b1;
                    pay_left_next = pay_left_next - 32'd1;
                    if (pay_left_next == '0)
                    begin
                        phase_next = PH_LENGTH;
                        acc_next   = '0;
                        seen_next  = '0;
                    end
                end
                default:
                begin
                    // dropping: the byte is consumed silently
                end
            endcase
        end

        desc_next.aud  = first_of_sample;
        desc_next.sc   = emit_sc;
        desc_next.pay  = emit_pay;
        desc_next.data = in_byte;

        desc_valid_next = desc_valid_reg && !desc_ready;
        if (accept)
        begin
            desc_valid_next = first_of_sample || emit_sc || emit_pay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg         <= FS_RESET;
            phase_reg      <= PH_LENGTH;
            acc_reg        <= '0;
            seen_reg       <= '0;
            pay_left_reg   <= '0;
            smp_left_reg   <= '0;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fs_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                seen_reg     <= seen_next;
                pay_left_reg <= pay_left_next;
                smp_left_reg <= smp_left_next;
            end
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_next;
        end
    end

    a_no_sc_with_payload: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg |-> !(desc_reg.sc && desc_reg.pay))
        else $error("start code and payload byte in one item");

    a_payload_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> pay_left_reg != '0)
        else $error("payload phase with nothing left");

    a_desc_held: assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid_reg && !desc_ready |=> desc_valid_reg && $stable(desc_reg))
        else $error("descriptor lost while waiting");

endmodule

// ----- hdl/nlsc_serial.sv -----
// output serializer: walks a descriptor byte by byte onto the master stream
`timescale 1ns / 1ps

module nlsc_serial
    import nlsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              desc_valid,
    output logic              desc_ready,
    input  desc_t             desc,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last
);

    desc_t            cur_reg;
    logic             cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;
    logic [IDX_W-1:0] end_idx;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] step_idx;
    logic             load;
    logic             at_end;

    assign end_idx   = cur_reg.pay ? IDX_PAY : (cur_reg.sc ? IDX_SC_LAST : IDX_AUD_LAST);
    assign at_end    = (idx_reg == end_idx);
    assign start_idx = desc.aud ? IDX_AUD_FIRST : (desc.sc ? IDX_SC_FIRST : IDX_PAY);
    assign step_idx  = (idx_reg == IDX_AUD_LAST && !cur_reg.sc) ? IDX_PAY : idx_reg + 4'd1;

    assign desc_ready = !cur_valid_reg || (out_ready && at_end);
    assign load       = desc_valid && desc_ready;

    assign out_valid = cur_valid_reg;
    assign out_byte  = list_byte(idx_reg, cur_reg.data);
    assign run_last  = at_end;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = 1'b1;
            idx_next       = start_idx;
        end
        else if (cur_valid_reg && out_ready)
        begin
            if (at_end)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = step_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= IDX_AUD_FIRST;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= desc;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg <= IDX_PAY)
        else $error("byte index out of range");

    a_aud_part: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && idx_reg <= IDX_AUD_LAST |-> cur_reg.aud)
        else $error("delimiter byte without delimiter request");

    a_sc_part: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && idx_reg >= IDX_SC_FIRST && idx_reg <= IDX_SC_LAST |-> cur_reg.sc)
        else $error("start code byte without start code request");

endmodule

// ----- hdl/nal_length_to_start_code.sv -----
// top level: length-prefixed sample bytes in, start-code framed bytes out
`timescale 1ns / 1ps
// result path: a descriptor registered in the parser is loaded into the serializer
// throughput: one input item per cycle while items give at most one byte each and
//   the output does not stall; items that open a sample give 6 delimiter bytes (9 with
//   a start code), a length byte completing a field gives 3, on one output byte lane
// reset: rst_n asynchronous active low; field size returns to 4, parser to length phase,
//   all counters and valid flags cleared

module nal_length_to_start_code
    import nlsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration: length_field_size
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,

    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] in_byte, [39:8] sample_length
    input  logic        s_axis_tuser,   // [0] first_of_sample

    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last byte caused by one input item
);

    // descriptor handoff between parser and serializer
    logic  desc_valid;
    logic  desc_ready;
    desc_t desc;

    // parser: tracks length fields and sample bytes, registers a descriptor per emitting item
    nlsc_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_byte         (s_axis_tdata[7:0]),
        .first_of_sample (s_axis_tuser),
        .sample_length   (s_axis_tdata[39:8]),
        .desc_valid      (desc_valid),
        .desc_ready      (desc_ready),
        .desc            (desc)
    );

    // serializer: expands delimiter, start code and payload byte onto the output
    nlsc_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .run_last   (m_axis_tlast)
    );

endmodule
